>>> hdl/drt_pkg.sv
package drt_pkg;

  localparam int ID_W      = 5;
  localparam int COST_W    = 16;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int DEFAULT_MAX_NODES = 16;

  localparam logic [COST_W-1:0] DEFAULT_INFINITY = 16'd10000;
  localparam logic [ID_W-1:0]   DEFAULT_OWN_NODE = 5'd1;

  // command codes
  localparam logic [FUNC_W-1:0] FN_LOAD_ROUTE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_NBR   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_VECTOR     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DISABLE    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INFINITY = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   node_id;
    logic [ID_W-1:0]   dest_id;
    logic [COST_W-1:0] link_cost;
    logic [ID_W-1:0]   hop_id;
    logic              link_update;
  } drt_req_t;

  typedef struct packed {
    logic [ID_W-1:0]   entry_id;
    logic [COST_W-1:0] entry_cost;
    logic [ID_W-1:0]   entry_next_hop;
    logic              changed;
  } drt_rsp_t;

  // one route table word
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
  } route_ent_t;

  // one link table word
  typedef struct packed {
    logic [COST_W-1:0] direct;
    logic              nbr;
  } link_ent_t;

  // write-back and follow-up requests from the update logic
  typedef struct packed {
    logic       route_we;
    route_ent_t route_ent;
    logic       link_we;
    link_ent_t  link_ent;
    logic       sweep;
  } drt_upd_t;

  // clamp a cost to the current infinity
  function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0]   v,
                                                 input logic [COST_W-1:0] inf);
    return (v >= {1'b0, inf}) ? inf : v[COST_W-1:0];
  endfunction

endpackage

>>> hdl/distance_vector_route_update.sv
// Distance-vector route table engine. It holds, per destination 1..MAX_NODES,
// a route cost and next hop, and per node a direct link cost and neighbour
// flag, in two single-port-write RAMs with registered reads. Each item on the
// req channel performs one command (load route, load neighbour, apply one
// received vector entry, disable a link) and yields exactly one item on the
// rsp channel describing the touched route entry. An ordinary item's result
// is loaded into the output register once the sender entry and the touched
// entry have been read one after the other through the shared read port,
// then updated and written back; a result still held in the output register
// delays it. No new item is accepted until the result has reached the output
// register. A received link-down entry addressed to this router also walks
// the whole route table once to invalidate routes through the sender, one
// table entry per cycle. The output register lets the next item be accepted
// while a result still waits. Memory contents are never cleared by a pass:
// per-entry valid bits, cleared at reset, make an unwritten entry read as its
// reset value. Configuration writes are accepted at any time but are expected
// only while the block is idle.
module distance_vector_route_update
  import drt_pkg::*;
#(
  parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COST_W-1:0]    cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  drt_req_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output drt_rsp_t             rsp
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_NODES - 1);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE      = 3'd0; // waiting, sender read goes out on accept
  localparam logic [ST_W-1:0] ST_RD_E      = 3'd1; // read touched entry, keep sender data
  localparam logic [ST_W-1:0] ST_CALC      = 3'd2; // update and write back
  localparam logic [ST_W-1:0] ST_SWEEP     = 3'd3; // walk the route table
  localparam logic [ST_W-1:0] ST_SWEEP_END = 3'd4; // last sweep write
  localparam logic [ST_W-1:0] ST_SEND      = 3'd5; // hand result to output register

  // configuration
  logic [ID_W-1:0]   own_node;
  logic [COST_W-1:0] infinity;

  // control
  logic [ST_W-1:0]  state;
  logic [ST_W-1:0]  state_next;
  drt_req_t         item;
  logic             use_dest;
  logic [IDX_W-1:0] sweep_idx;
  logic             sweep_pend;
  logic [IDX_W-1:0] rd_idx_q;

  // captured sender entry and held result
  route_ent_t s_rt_q;
  logic       s_nbr_q;
  drt_rsp_t   res_q;

  // valid bits, an unset one means the entry still has its reset value
  logic [MAX_NODES-1:0] route_vld;
  logic [MAX_NODES-1:0] link_vld;

  // memory ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             route_we;
  logic [IDX_W-1:0] route_waddr;
  route_ent_t       route_wdata;
  route_ent_t       route_rdata;
  logic             link_we;
  link_ent_t        link_rdata;

  // effective read values
  route_ent_t rt_eff;
  link_ent_t  lk_eff;

  logic             req_fire;
  logic             rsp_fire;
  logic [IDX_W-1:0] s_idx;
  logic [IDX_W-1:0] e_idx;
  logic             sweep_hit;
  drt_rsp_t         calc_res;
  drt_upd_t         upd;

  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_fire  = rsp_valid && !rsp_stall;

  assign s_idx = IDX_W'(item.node_id - ID_W'(1));
  assign e_idx = use_dest ? IDX_W'(item.dest_id - ID_W'(1)) : s_idx;

  // read port: sender on accept, touched entry next, then the sweep walk
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sweep_idx;
    case (state)
      ST_IDLE: begin
        rd_en   = req_fire;
        rd_addr = IDX_W'(req.node_id - ID_W'(1));
      end
      ST_RD_E: begin
        rd_en   = 1'b1;
        rd_addr = e_idx;
      end
      ST_SWEEP: begin
        rd_en   = 1'b1;
        rd_addr = sweep_idx;
      end
      default: begin
      end
    endcase
  end

  // unwritten entries: cost at the reset infinity, next hop is index plus one
  always_comb begin
    rt_eff = route_rdata;
    lk_eff = link_rdata;
    if (!route_vld[rd_idx_q]) begin
      rt_eff.cost = DEFAULT_INFINITY;
      rt_eff.hop  = ID_W'(rd_idx_q) + ID_W'(1);
    end
    if (!link_vld[rd_idx_q]) begin
      lk_eff = '{direct: DEFAULT_INFINITY, nbr: 1'b0};
    end
  end

  drt_calc #(
    .MAX_NODES(MAX_NODES)
  ) u_calc (
    .item       (item),
    .use_dest   (use_dest),
    .same_entry (s_idx == e_idx),
    .infinity   (infinity),
    .s_rt       (s_rt_q),
    .s_nbr      (s_nbr_q),
    .e_rt       (rt_eff),
    .e_lk       (lk_eff),
    .result     (calc_res),
    .upd        (upd)
  );

  // sweep kills every route whose next hop is the sender
  assign sweep_hit = sweep_pend && (rt_eff.hop == item.node_id);

  // write ports: only one write source is active in any state
  always_comb begin
    route_we    = 1'b0;
    route_waddr = e_idx;
    route_wdata = upd.route_ent;
    if (state == ST_CALC) begin
      route_we = upd.route_we;
    end else if (sweep_hit) begin
      route_we    = 1'b1;
      route_waddr = rd_idx_q;
      route_wdata = '{cost: infinity, hop: rt_eff.hop};
    end
  end

  // every link write goes to the sender's entry
  assign link_we = (state == ST_CALC) && upd.link_we;

  drt_ram #(
    .WIDTH($bits(route_ent_t)),
    .DEPTH(MAX_NODES)
  ) u_route_ram (
    .clk   (clk),
    .we    (route_we),
    .waddr (route_waddr),
    .wdata (route_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (route_rdata)
  );

  drt_ram #(
    .WIDTH($bits(link_ent_t)),
    .DEPTH(MAX_NODES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (s_idx),
    .wdata (upd.link_ent),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_RD_E;
        end
      end
      ST_RD_E: begin
        state_next = ST_CALC;
      end
      ST_CALC: begin
        state_next = upd.sweep ? ST_SWEEP : ST_SEND;
      end
      ST_SWEEP: begin
        if (sweep_idx == SWEEP_LAST) begin
          state_next = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        // wait until the output register is free
        if (!rsp_valid || rsp_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      own_node   <= DEFAULT_OWN_NODE;
      infinity   <= DEFAULT_INFINITY;
      route_vld  <= '0;
      link_vld   <= '0;
      rsp_valid  <= 1'b0;
      sweep_pend <= 1'b0;
      sweep_idx  <= '0;
    end else begin
      state      <= state_next;
      sweep_pend <= (state == ST_SWEEP);

      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_NODE: own_node <= cfg_data[ID_W-1:0];
          CFG_INFINITY: infinity <= cfg_data;
          default: begin
          end
        endcase
      end

      if (route_we) begin
        route_vld[route_waddr] <= 1'b1;
      end
      if (link_we) begin
        link_vld[s_idx] <= 1'b1;
      end

      if (state == ST_CALC) begin
        sweep_idx <= '0;
      end else if (state == ST_SWEEP) begin
        sweep_idx <= sweep_idx + IDX_W'(1);
      end

      if (state == ST_SEND && (!rsp_valid || rsp_fire)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_fire) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item     <= req;
      use_dest <= (req.func == FN_VECTOR) && (req.dest_id != own_node);
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (state == ST_RD_E) begin
      s_rt_q  <= rt_eff;
      s_nbr_q <= lk_eff.nbr;
    end
    if (state == ST_CALC) begin
      res_q <= calc_res;
    end
    if (state == ST_SEND && (!rsp_valid || rsp_fire)) begin
      rsp <= res_q;
    end
  end

  // table writes happen only in the update and sweep states
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    (route_we || link_we) |->
      (state == ST_CALC || state == ST_SWEEP || state == ST_SWEEP_END))
    else $error("table write outside update or sweep");

  // a sweep write always marks the route unreachable
  a_sweep_inf: assert property (@(posedge clk) disable iff (rst)
    (route_we && state != ST_CALC) |-> (route_wdata.cost == infinity))
    else $error("sweep wrote a finite cost");

  // the sweep ends only after the last entry was read
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP_END) |-> (rd_idx_q == SWEEP_LAST && sweep_pend))
    else $error("sweep ended early");

  // a held result keeps the sequencer waiting
  a_send_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND && rsp_valid && rsp_stall) |=> (state == ST_SEND))
    else $error("result dropped while output stalled");

endmodule

>>> hdl/drt_ram.sv
module drt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/drt_calc.sv
module drt_calc
  import drt_pkg::*;
#(
  parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
  input  drt_req_t          item,
  input  logic              use_dest,
  input  logic              same_entry,
  input  logic [COST_W-1:0] infinity,
  input  route_ent_t        s_rt,
  input  logic              s_nbr,
  input  route_ent_t        e_rt,
  input  link_ent_t         e_lk,
  output drt_rsp_t          result,
  output drt_upd_t          upd
);

  logic [COST_W-1:0] sat_c;
  logic [COST_W-1:0] cost_e_sat;
  logic [COST_W-1:0] cost_s_sat;
  logic [COST_W-1:0] sum;
  logic [COST_W-1:0] dir_e_sat;
  logic              nid_ok;
  logic              did_ok;
  logic              bad;

  assign nid_ok = (item.node_id != '0) && (32'(item.node_id) <= MAX_NODES);
  assign did_ok = (item.dest_id != '0) && (32'(item.dest_id) <= MAX_NODES);
  assign bad    = !nid_ok || (use_dest && !did_ok);

  assign sat_c      = sat_cost({1'b0, item.link_cost}, infinity);
  assign cost_e_sat = sat_cost({1'b0, e_rt.cost}, infinity);
  assign cost_s_sat = sat_cost({1'b0, s_rt.cost}, infinity);
  assign sum        = sat_cost({1'b0, cost_s_sat} + {1'b0, item.link_cost}, infinity);
  // sender and destination may share an entry whose direct cost changes now
  assign dir_e_sat  = (item.link_update && s_nbr && same_entry) ? sat_c
                    : sat_cost({1'b0, e_lk.direct}, infinity);

  always_comb begin
    route_ent_t nxt;
    nxt = e_rt;
    upd = '0;

    case (item.func)
      FN_LOAD_ROUTE: begin
        nxt.cost     = sat_c;
        nxt.hop      = item.hop_id;
        upd.route_we = 1'b1;
      end
      FN_LOAD_NBR: begin
        upd.link_we  = 1'b1;
        upd.link_ent = '{direct: sat_c, nbr: 1'b1};
      end
      FN_VECTOR: begin
        if (item.link_update && s_nbr) begin
          upd.link_we  = 1'b1;
          upd.link_ent = '{direct: sat_c, nbr: 1'b1};
        end
        upd.sweep = item.link_update && (item.link_cost >= infinity) && !use_dest;
        if (use_dest) begin
          if (e_rt.hop != item.node_id) begin
            if (sum < cost_e_sat) begin
              nxt.cost     = sum;
              nxt.hop      = s_rt.hop;
              upd.route_we = 1'b1;
            end
          end else begin
            nxt.cost     = sum;
            upd.route_we = 1'b1;
            // direct link beats the path through the sender
            if (e_lk.nbr && (dir_e_sat < sum)) begin
              nxt.cost = dir_e_sat;
              nxt.hop  = item.dest_id;
            end
          end
        end else begin
          if (e_rt.hop != item.node_id) begin
            if (sat_c < cost_e_sat) begin
              nxt.cost     = sat_c;
              nxt.hop      = item.node_id;
              upd.route_we = 1'b1;
            end
          end else begin
            nxt.cost     = sat_c;
            upd.route_we = 1'b1;
          end
        end
      end
      FN_DISABLE: begin
        if (e_lk.nbr) begin
          upd.link_we  = 1'b1;
          upd.link_ent = '{direct: infinity, nbr: 1'b1};
          if (e_rt.hop == item.node_id) begin
            nxt.cost     = infinity;
            upd.route_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    upd.route_ent = nxt;

    result.entry_id       = use_dest ? item.dest_id : item.node_id;
    result.entry_cost     = sat_cost({1'b0, nxt.cost}, infinity);
    result.entry_next_hop = nxt.hop;
    result.changed        = (result.entry_cost != cost_e_sat) || (nxt.hop != e_rt.hop);

    if (bad) begin
      upd    = '0;
      result = '{entry_id: item.node_id, entry_cost: infinity,
                 entry_next_hop: '0, changed: 1'b0};
    end
  end

endmodule
